// ===== hdl/efv_pkg.sv =====
// Shared types, constants and the CRC byte step for the envelope frame validator.
`timescale 1ns / 1ps

package efv_pkg;

  // Frame layout and counter limits.
  localparam int HEADER_BYTES    = 20;
  localparam int COUNT_WIDTH_DEF = 24;
  // Wide enough for the byte total and for the header size plus a 32-bit length.
  localparam int CMP_W           = 33;

  // Reflected CRC-32 polynomial.
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

  // Configuration register indexes.
  localparam logic [1:0] CFG_MAGIC   = 2'd0;
  localparam logic [1:0] CFG_SCHEMA  = 2'd1;
  localparam logic [1:0] CFG_EXP_LEN = 2'd2;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_VALID        = 3'd0,
    ST_NOT_ENVELOPE = 3'd1,
    ST_MALFORMED    = 3'd2,
    ST_SCHEMA_NEWER = 3'd3,
    ST_CHECKSUM     = 3'd4
  } status_t;

  // One input item as held in the input register.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } step_t;

  // Configuration values seen by the frame tracker.
  typedef struct packed {
    logic [31:0] magic;
    logic [15:0] schema;
    logic [23:0] exp_len;
  } cfg_t;

  // One result item.
  typedef struct packed {
    status_t     status;
    logic        preserve;
    logic [31:0] magic;
    logic [15:0] schema;
    logic [15:0] reserved;
    logic [31:0] length;
    logic [31:0] revision;
    logic [31:0] crc;
    logic        payload_ok;
  } result_t;

  // Fold one byte into a reflected CRC-32 accumulator.
  function automatic logic [31:0] crc_byte(input logic [31:0] c_in, input logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
    end
    return c;
  endfunction

endpackage

// ===== hdl/envelope_frame_validator.sv =====
// Top level of the envelope frame validator: input register, frame tracker, result register.
`timescale 1ns / 1ps

// Usage:
// A blob enters one byte per item on the in_ channel, with in_last_byte set on its
// final byte. The first 20 bytes are a little-endian header (magic, schema, reserved,
// payload length, revision, payload CRC); the rest is payload, covered by a reflected
// CRC-32. Each final byte gives one result item on the out_ channel: a status code,
// the preserve and payload_ok flags and the captured header fields. Other bytes give
// no result.
// An accepted byte is processed by the frame tracker while it sits in the input
// register; when a final byte leaves it, the result register loads its result,
// which then shows on the out_ ports. One byte is taken every cycle unless a final
// byte waits for a blocked result; the rate is set by the byte CRC step and
// header capture in the tracker.
// The cfg_ port writes the expected magic, the supported schema version and the
// expected payload length; write it only while no blob is in progress.
// Synchronous reset clears the frame state and both valid flags and restores the
// register defaults. While the receiver stalls, a held result stays stable; further
// non-final bytes keep flowing, and a final byte waits in the input register.

module envelope_frame_validator #(
  parameter int COUNT_WIDTH = efv_pkg::COUNT_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration writes.
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  // Input channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  // Result channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic        out_preserve,
  output logic [31:0] out_header_magic,
  output logic [15:0] out_header_schema,
  output logic [15:0] out_header_reserved,
  output logic [31:0] out_header_length,
  output logic [31:0] out_header_revision,
  output logic [31:0] out_header_crc,
  output logic        out_payload_ok
);

  efv_pkg::cfg_t    cfg_r;
  logic             s1_valid_r, s1_valid_nxt;
  efv_pkg::step_t   s1_step_r;
  logic             s1_adv;
  logic             in_accept;
  efv_pkg::result_t step_res;
  logic             out_valid_r, out_valid_nxt;
  efv_pkg::result_t out_res_r;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.magic   <= 32'd0;
      cfg_r.schema  <= 16'd1;
      cfg_r.exp_len <= 24'd0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        efv_pkg::CFG_MAGIC:   cfg_r.magic   <= cfg_wdata;
        efv_pkg::CFG_SCHEMA:  cfg_r.schema  <= cfg_wdata[15:0];
        efv_pkg::CFG_EXP_LEN: cfg_r.exp_len <= cfg_wdata[23:0];
        default: ;
      endcase
    end
  end

  // A held byte moves on unless it is a final byte and the result register is blocked.
  assign s1_adv    = s1_valid_r && !(s1_step_r.last && out_valid_r && out_stall);
  assign in_stall  = s1_valid_r && !s1_adv;
  assign in_accept = in_valid && !in_stall;

  // Input register.
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_accept) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_step_r.data <= in_data_byte;
      s1_step_r.last <= in_last_byte;
    end
  end

  efv_frame_tracker #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_tracker (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_valid (s1_adv),
    .step       (s1_step_r),
    .cfg        (cfg_r),
    .res        (step_res)
  );

  // Result register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv && s1_step_r.last) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_step_r.last) begin
      out_res_r <= step_res;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_res_r.status;
  assign out_preserve        = out_res_r.preserve;
  assign out_header_magic    = out_res_r.magic;
  assign out_header_schema   = out_res_r.schema;
  assign out_header_reserved = out_res_r.reserved;
  assign out_header_length   = out_res_r.length;
  assign out_header_revision = out_res_r.revision;
  assign out_header_crc      = out_res_r.crc;
  assign out_payload_ok      = out_res_r.payload_ok;

endmodule

// ===== hdl/efv_frame_tracker.sv =====
// Frame state: header capture, payload CRC, byte count and the end-of-frame checks.
`timescale 1ns / 1ps

module efv_frame_tracker #(
  parameter int COUNT_WIDTH = efv_pkg::COUNT_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step_valid,
  input  efv_pkg::step_t   step,
  input  efv_pkg::cfg_t    cfg,
  output efv_pkg::result_t res
);

  logic [COUNT_WIDTH-1:0] count_r, count_nxt;
  logic [31:0] magic_r, magic_nxt, magic_cap;
  logic [15:0] schema_r, schema_nxt, schema_cap;
  logic [15:0] rsvd_r, rsvd_nxt, rsvd_cap;
  logic [31:0] length_r, length_nxt, length_cap;
  logic [31:0] rev_r, rev_nxt, rev_cap;
  logic [31:0] scrc_r, scrc_nxt, scrc_cap;
  logic [31:0] crc_r, crc_nxt, crc_cap;

  logic [4:0]                 idx;
  logic                       in_hdr;
  logic                       sat;
  logic [efv_pkg::CMP_W-1:0]  total;
  logic [efv_pkg::CMP_W-1:0]  len_sum;
  logic                       bad_fields;

  assign idx    = count_r[4:0];
  assign in_hdr = count_r < COUNT_WIDTH'(efv_pkg::HEADER_BYTES);
  assign sat    = count_r == {COUNT_WIDTH{1'b1}};

  // Capture the byte into its header field, or fold it into the payload CRC.
  always_comb begin
    magic_cap  = magic_r;
    schema_cap = schema_r;
    rsvd_cap   = rsvd_r;
    length_cap = length_r;
    rev_cap    = rev_r;
    scrc_cap   = scrc_r;
    crc_cap    = crc_r;
    if (step_valid) begin
      if (in_hdr) begin
        case (idx) inside
          [5'd0:5'd3]:   magic_cap[{idx[1:0], 3'b000} +: 8] = step.data;
          [5'd4:5'd5]:   schema_cap[{idx[0], 3'b000} +: 8] = step.data;
          [5'd6:5'd7]:   rsvd_cap[{idx[0], 3'b000} +: 8] = step.data;
          [5'd8:5'd11]:  length_cap[{idx[1:0], 3'b000} +: 8] = step.data;
          [5'd12:5'd15]: rev_cap[{idx[1:0], 3'b000} +: 8] = step.data;
          default:       scrc_cap[{idx[1:0], 3'b000} +: 8] = step.data;
        endcase
      end else begin
        crc_cap = efv_pkg::crc_byte(crc_r, step.data);
      end
    end
  end

  // Blob length including this byte, and the length the header implies.
  assign total   = efv_pkg::CMP_W'(count_r) + efv_pkg::CMP_W'(1);
  assign len_sum = efv_pkg::CMP_W'(efv_pkg::HEADER_BYTES) + efv_pkg::CMP_W'(length_cap);

  assign bad_fields = (schema_cap != cfg.schema) || (rsvd_cap != 16'd0) ||
                      (rev_cap == 32'd0) || (length_cap != {8'd0, cfg.exp_len}) ||
                      sat || (total != len_sum);

  // End-of-frame checks in priority order.
  always_comb begin
    res = '0;
    if ((total < efv_pkg::CMP_W'(4)) || (magic_cap != cfg.magic)) begin
      res.status = efv_pkg::ST_NOT_ENVELOPE;
    end else if (total < efv_pkg::CMP_W'(efv_pkg::HEADER_BYTES)) begin
      res.status = efv_pkg::ST_MALFORMED;
    end else begin
      res.magic    = magic_cap;
      res.schema   = schema_cap;
      res.reserved = rsvd_cap;
      res.length   = length_cap;
      res.revision = rev_cap;
      res.crc      = scrc_cap;
      if (schema_cap > cfg.schema) begin
        res.status = efv_pkg::ST_SCHEMA_NEWER;
      end else if (bad_fields) begin
        res.status = efv_pkg::ST_MALFORMED;
      end else if (scrc_cap != ~crc_cap) begin
        res.status = efv_pkg::ST_CHECKSUM;
      end else begin
        res.status = efv_pkg::ST_VALID;
      end
    end
    res.preserve   = (res.status == efv_pkg::ST_MALFORMED) ||
                     (res.status == efv_pkg::ST_SCHEMA_NEWER) ||
                     (res.status == efv_pkg::ST_CHECKSUM);
    res.payload_ok = res.status == efv_pkg::ST_VALID;
  end

  // Advance the count, and clear the frame after its last byte.
  always_comb begin
    magic_nxt  = magic_cap;
    schema_nxt = schema_cap;
    rsvd_nxt   = rsvd_cap;
    length_nxt = length_cap;
    rev_nxt    = rev_cap;
    scrc_nxt   = scrc_cap;
    crc_nxt    = crc_cap;
    count_nxt  = count_r;
    if (step_valid) begin
      if (!sat) begin
        count_nxt = count_r + COUNT_WIDTH'(1);
      end
      if (step.last) begin
        count_nxt  = '0;
        magic_nxt  = '0;
        schema_nxt = '0;
        rsvd_nxt   = '0;
        length_nxt = '0;
        rev_nxt    = '0;
        scrc_nxt   = '0;
        crc_nxt    = '1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      magic_r  <= '0;
      schema_r <= '0;
      rsvd_r   <= '0;
      length_r <= '0;
      rev_r    <= '0;
      scrc_r   <= '0;
      crc_r    <= '1;
    end else begin
      count_r  <= count_nxt;
      magic_r  <= magic_nxt;
      schema_r <= schema_nxt;
      rsvd_r   <= rsvd_nxt;
      length_r <= length_nxt;
      rev_r    <= rev_nxt;
      scrc_r   <= scrc_nxt;
      crc_r    <= crc_nxt;
    end
  end

endmodule

// ===== hdl/efv_checker.sv =====
// Port-level checks for the envelope frame validator, bound to its top level.
`timescale 1ns / 1ps

module efv_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_status,
  input logic        out_preserve,
  input logic [31:0] out_header_magic,
  input logic [15:0] out_header_schema,
  input logic [31:0] out_header_length,
  input logic        out_payload_ok
);

  // The input side is only held back while a result is blocked downstream.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while the result register is free");

  // The flags follow the status code.
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_payload_ok == (out_status == efv_pkg::ST_VALID)) &&
                   (out_preserve == ((out_status == efv_pkg::ST_MALFORMED) ||
                                     (out_status == efv_pkg::ST_SCHEMA_NEWER) ||
                                     (out_status == efv_pkg::ST_CHECKSUM)))))
    else $error("preserve or payload_ok disagrees with status");

  // A blob that is not an envelope shows no header.
  a_no_header: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == efv_pkg::ST_NOT_ENVELOPE)) |->
      ((out_header_magic == 32'd0) && (out_header_schema == 16'd0) &&
       (out_header_length == 32'd0)))
    else $error("header fields shown for a non-envelope blob");

  // Only defined status codes appear.
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status <= efv_pkg::ST_CHECKSUM))
    else $error("undefined status code");

endmodule

bind envelope_frame_validator efv_checker u_efv_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_status        (out_status),
  .out_preserve      (out_preserve),
  .out_header_magic  (out_header_magic),
  .out_header_schema (out_header_schema),
  .out_header_length (out_header_length),
  .out_payload_ok    (out_payload_ok)
);
